>>> hw/rtl/iirl_pkg.sv
// Types and constants shared by the indexed insert/remove list.
`timescale 1ns / 1ps

package iirl_pkg;

  localparam int OP_W     = 3;
  localparam int INDEX_W  = 4;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;

  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 40;

  localparam int S_OP_LSB    = 0;
  localparam int S_INDEX_LSB = S_OP_LSB + OP_W;
  localparam int S_VALUE_LSB = S_INDEX_LSB + INDEX_W;

  localparam int M_STATUS_LSB = 0;
  localparam int M_DATA_LSB   = M_STATUS_LSB + STATUS_W;
  localparam int M_FILL_LSB   = M_DATA_LSB + VALUE_W;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_POP    = 3'd2,
    OP_REMOVE = 3'd3,
    OP_READ   = 3'd4
  } op_code_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_INSERT,
    ACT_REMOVE
  } shift_act_t;

endpackage

>>> hw/rtl/indexed_insert_remove_list_unit.sv
// Top level of the indexed insert/remove list with its row of cells.
`timescale 1ns / 1ps
// Usage:
//   Input words arrive on s_tvalid/s_tready/s_tdata, one operation each:
//   append, insert at index, pop last, remove at index or read at index.
//   Every input word yields exactly one result word on m_tvalid/m_tready/
//   m_tdata carrying status, data and the element count afterwards.
//   The result is registered at the edge that accepts the word. While the
//   receiver keeps up, throughput is one word per cycle; every cell of the row
//   shifts toward its neighbor in parallel for each update.
//   When the receiver stalls, the result register holds and s_tready drops
//   until it is taken; a new word is accepted in the cycle the old result
//   leaves. Reset clears the count and every cell to zero and empties the
//   result register. CAPACITY sets the number of cells (2 to 256); fill
//   reports the low 5 bits of the count.

module indexed_insert_remove_list_unit
  import iirl_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // op[2:0], index[6:3], value[38:7], zero pad
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata   // status[1:0], data[33:2], fill[38:34], zero pad
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  logic [CNT_W-1:0]          cnt;
  logic [CNT_W-1:0]          cnt_next;
  logic                      accept;
  op_code_t                  op;
  logic [INDEX_W-1:0]        index;
  logic signed [VALUE_W-1:0] value;
  logic [CMP_W-1:0]          pos_c;
  logic [CMP_W-1:0]          cnt_c;
  logic                      full;
  logic                      empty;
  shift_act_t                act;
  logic [CNT_W-1:0]          lo;
  logic [CNT_W-1:0]          hi;
  logic [CMP_W-1:0]          rd_addr;
  logic                      rd_en;
  logic signed [VALUE_W-1:0] rd_data;
  status_t                   status;
  logic signed [VALUE_W-1:0] res_data;
  logic signed [VALUE_W-1:0] elems [CAPACITY];

  assign accept = s_tvalid && s_tready;
  assign s_tready = !m_tvalid || m_tready;

  assign op    = op_code_t'(s_tdata[S_OP_LSB +: OP_W]);
  assign index = s_tdata[S_INDEX_LSB +: INDEX_W];
  assign value = s_tdata[S_VALUE_LSB +: VALUE_W];

  assign pos_c = CMP_W'(index);
  assign cnt_c = CMP_W'(cnt);
  assign full  = (cnt == CNT_W'(CAPACITY));
  assign empty = (cnt == '0);

  always_comb begin
    act      = ACT_HOLD;
    lo       = '0;
    hi       = '0;
    rd_en    = 1'b0;
    rd_addr  = '0;
    status   = ST_OK;
    cnt_next = cnt;
    case (op)
      OP_APPEND: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          act      = ACT_INSERT;
          lo       = cnt;
          hi       = cnt;
          cnt_next = cnt + 1'b1;
        end
      end
      OP_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else if (pos_c > cnt_c) begin
          status = ST_RANGE;
        end else begin
          act      = ACT_INSERT;
          lo       = CNT_W'(pos_c);
          hi       = cnt;
          cnt_next = cnt + 1'b1;
        end
      end
      OP_POP: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          act      = ACT_REMOVE;
          lo       = cnt - 1'b1;
          hi       = cnt - 1'b1;
          rd_en    = 1'b1;
          rd_addr  = cnt_c - 1'b1;
          cnt_next = cnt - 1'b1;
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (pos_c >= cnt_c) begin
          status = ST_RANGE;
        end else begin
          act      = ACT_REMOVE;
          lo       = CNT_W'(pos_c);
          hi       = cnt - 1'b1;
          cnt_next = cnt - 1'b1;
        end
      end
      OP_READ: begin
        if (pos_c >= cnt_c) begin
          status = ST_RANGE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = pos_c;
        end
      end
      default: status = ST_OK;
    endcase
  end

  always_comb begin
    rd_data = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (rd_addr == CMP_W'(k)) begin
        rd_data = elems[k];
      end
    end
  end

  assign res_data = rd_en ? rd_data : '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [VALUE_W-1:0] from_low;
    logic signed [VALUE_W-1:0] from_high;

    if (g == 0) begin : g_first
      assign from_low = '0;
    end else begin : g_mid_low
      assign from_low = elems[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign from_high = '0;
    end else begin : g_mid_high
      assign from_high = elems[g+1];
    end

    iirl_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .act       (accept ? act : ACT_HOLD),
      .lo        (lo),
      .hi        (hi),
      .value     (value),
      .from_low  (from_low),
      .from_high (from_high),
      .elem      (elems[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        cnt      <= cnt_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {(M_DATA_W - FILL_W - VALUE_W - STATUS_W)'(0),
                  FILL_W'(cnt_next), res_data, status};
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_fill_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[M_FILL_LSB +: FILL_W] == FILL_W'(cnt))
    else $error("reported fill differs from count");

  a_err_no_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[M_STATUS_LSB +: STATUS_W] != ST_OK
    |-> m_tdata[M_DATA_LSB +: VALUE_W] == '0)
    else $error("data nonzero on error status");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_APPEND && full |=> cnt == CNT_W'(CAPACITY))
    else $error("append on full list changed count");
`endif

endmodule

>>> hw/rtl/iirl_cell.sv
// One storage cell of the list: holds one element, loads, shifts or clears.
`timescale 1ns / 1ps

module iirl_cell
  import iirl_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  shift_act_t                act,
  input  logic [CNT_W-1:0]          lo,
  input  logic [CNT_W-1:0]          hi,
  input  logic signed [VALUE_W-1:0] value,
  input  logic signed [VALUE_W-1:0] from_low,
  input  logic signed [VALUE_W-1:0] from_high,
  output logic signed [VALUE_W-1:0] elem
);

  localparam logic [CNT_W-1:0] MY = CNT_W'(IDX);

  logic signed [VALUE_W-1:0] elem_next;

  always_comb begin
    elem_next = elem;
    case (act)
      ACT_INSERT: begin
        if (MY == lo) begin
          elem_next = value;
        end else if (MY > lo && MY <= hi) begin
          elem_next = from_low;
        end
      end
      ACT_REMOVE: begin
        if (MY == hi) begin
          elem_next = '0;
        end else if (MY >= lo && MY < hi) begin
          elem_next = from_high;
        end
      end
      default: elem_next = elem;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elem <= '0;
    end else begin
      elem <= elem_next;
    end
  end

endmodule
